// ===== src/mfc_pkg.sv =====
// Shared types and constants for the Mandelbrot checksum unit.
// No dependencies; imported by every module of the block except mfc_div.
`default_nettype none

package mfc_pkg;

	localparam int DIM_IN_W      = 11;
	localparam int ITER_IN_W     = 10;
	localparam int SUM_W         = 30;

	localparam int FRAC_BITS_DEF = 24;
	localparam int MAX_DIM_DEF   = 1024;
	localparam int MAX_ITER_DEF  = 1023;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_RE,
		ST_DIV_IM,
		ST_MUL,
		ST_UPD,
		ST_DONE
	} mfc_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic div_start;
		logic div_im;
		logic cap_re;
		logic cap_im;
		logic mul;
		logic iterate;
		logic next_point;
	} mfc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic div_done;
		logic point_end;
		logic last_point;
	} mfc_status_t;

endpackage

`default_nettype wire

// ===== src/mfc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by mfc_datapath for the two grid steps.
`default_nettype none

module mfc_div #(
	parameter int DVD_W = 26,
	parameter int DVS_W = 11
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic      [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;

	logic [DVS_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== src/mfc_datapath.sv =====
// Datapath: grid stepping, escape-time iteration and checksum accumulation.
// Depends on mfc_pkg and mfc_div; driven by mfc_ctrl commands.
`default_nettype none

module mfc_datapath
	import mfc_pkg::*;
#(
	parameter int FRAC_BITS      = FRAC_BITS_DEF,
	parameter int MAX_DIM        = MAX_DIM_DEF,
	parameter int MAX_ITER_LIMIT = MAX_ITER_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [DIM_IN_W-1:0]  width,
	input  wire logic [DIM_IN_W-1:0]  height,
	input  wire logic [ITER_IN_W-1:0] iter_limit,
	input  wire mfc_cmd_t             cmd,
	output mfc_status_t               st,
	output logic      [SUM_W-1:0]     checksum
);

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int ITER_W = $clog2(MAX_ITER_LIMIT + 1);
	localparam int DVD_W  = FRAC_BITS + 2;
	localparam int Z_W    = FRAC_BITS + 4;   // |z| < 8 at all times
	localparam int P_W    = 2 * Z_W;
	localparam int SQ_W   = FRAC_BITS + 8;   // squares of |z| < 8
	localparam int RI_W   = FRAC_BITS + 9;   // 2*zr*zi

	localparam logic signed [63:0] ONE    = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] RE_MIN = -((64'sd5 * ONE) >>> 1);
	localparam logic signed [63:0] IM_MIN = -ONE;
	localparam logic signed [63:0] FOUR   = 64'sd4 * ONE;
	localparam logic [63:0]        DVD_RE = 64'((64'sd7 * ONE) >>> 1);
	localparam logic [63:0]        DVD_IM = 64'(64'sd2 * ONE);

	logic        [DIM_W-1:0]  w_q, h_q, col_q, row_q;
	logic        [ITER_W-1:0] lim_q, iter_q;
	logic signed [Z_W-1:0]    step_re_q, step_im_q;
	logic signed [Z_W-1:0]    c_re_q, c_im_q, zr_q, zi_q;
	logic signed [SQ_W-1:0]   rr_s1, ii_s1;
	logic signed [RI_W-1:0]   ri_s1;
	logic        [SUM_W-1:0]  sum_q;

	logic        [DIM_W-1:0]  w_sat, h_sat;
	logic        [ITER_W-1:0] lim_sat;
	logic signed [P_W-1:0]    zr_x, zi_x, p_rr, p_ii, p_ri;
	logic signed [SQ_W:0]     mag;
	logic signed [RI_W-1:0]   nr_full, ni_full;
	logic        [DVD_W-1:0]  div_dvd, div_quo;
	logic        [DIM_W-1:0]  div_dvs;
	logic                     div_done;
	logic                     last_col, last_row;

	assign w_sat   = (32'(width) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(width);
	assign h_sat   = (32'(height) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(height);
	assign lim_sat = (32'(iter_limit) > MAX_ITER_LIMIT) ?
		ITER_W'(MAX_ITER_LIMIT) : ITER_W'(iter_limit);

	assign div_dvd = cmd.div_im ? DVD_W'(DVD_IM) : DVD_W'(DVD_RE);
	assign div_dvs = cmd.div_im ? h_q : w_q;

	mfc_div #(
		.DVD_W(DVD_W),
		.DVS_W(DIM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.done    (div_done),
		.quotient(div_quo)
	);

	// squares and cross product, registered before use
	assign zr_x = P_W'(zr_q);
	assign zi_x = P_W'(zi_q);
	assign p_rr = zr_x * zr_x;
	assign p_ii = zi_x * zi_x;
	assign p_ri = zr_x * zi_x;

	assign mag     = (SQ_W + 1)'(rr_s1) + (SQ_W + 1)'(ii_s1);
	// only taken when mag <= 4, so both fit back into Z_W
	assign nr_full = RI_W'(rr_s1) - RI_W'(ii_s1) + RI_W'(c_re_q);
	assign ni_full = ri_s1 + RI_W'(c_im_q);

	assign last_col = (col_q + DIM_W'(1)) == w_q;
	assign last_row = (row_q + DIM_W'(1)) == h_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q    <= w_sat;
			h_q    <= h_sat;
			lim_q  <= lim_sat;
			sum_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
			c_re_q <= Z_W'(RE_MIN);
			c_im_q <= Z_W'(IM_MIN);
			zr_q   <= '0;
			zi_q   <= '0;
			iter_q <= '0;
		end
		if (cmd.cap_re) begin
			step_re_q <= Z_W'(div_quo);
		end
		if (cmd.cap_im) begin
			step_im_q <= Z_W'(div_quo);
		end
		if (cmd.mul) begin
			rr_s1 <= SQ_W'(p_rr >>> FRAC_BITS);
			ii_s1 <= SQ_W'(p_ii >>> FRAC_BITS);
			ri_s1 <= RI_W'(p_ri >>> (FRAC_BITS - 1));
		end
		if (cmd.iterate) begin
			zr_q   <= Z_W'(nr_full);
			zi_q   <= Z_W'(ni_full);
			iter_q <= iter_q + ITER_W'(1);
		end
		if (cmd.next_point) begin
			sum_q  <= sum_q + SUM_W'(iter_q);
			zr_q   <= '0;
			zi_q   <= '0;
			iter_q <= '0;
			if (last_col) begin
				col_q  <= '0;
				row_q  <= row_q + DIM_W'(1);
				c_re_q <= Z_W'(RE_MIN);
				c_im_q <= c_im_q + step_im_q;
			end else begin
				col_q  <= col_q + DIM_W'(1);
				c_re_q <= c_re_q + step_re_q;
			end
		end
	end

	assign st.empty      = (w_q == '0) || (h_q == '0);
	assign st.div_done   = div_done;
	assign st.point_end  = (iter_q >= lim_q) || (mag > (SQ_W + 1)'(FOUR));
	assign st.last_point = last_col && last_row;

	assign checksum = sum_q;

endmodule

`default_nettype wire

// ===== src/mfc_ctrl.sv =====
// Controller state machine: job sequencing, divisions, iteration loop.
// Depends on mfc_pkg; issues commands to mfc_datapath.
`default_nettype none

module mfc_ctrl
	import mfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire mfc_status_t st,
	output mfc_cmd_t         cmd,
	output logic             busy,
	output logic             done
);

	mfc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (st.empty) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV_RE;
				end
			end
			ST_DIV_RE: begin
				if (st.div_done) begin
					cmd.cap_re    = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_im    = 1'b1;
					state_d       = ST_DIV_IM;
				end
			end
			ST_DIV_IM: begin
				cmd.div_im = 1'b1;
				if (st.div_done) begin
					cmd.cap_im = 1'b1;
					state_d    = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (st.point_end) begin
					cmd.next_point = 1'b1;
					state_d        = st.last_point ? ST_DONE : ST_MUL;
				end else begin
					cmd.iterate = 1'b1;
					state_d     = ST_MUL;
				end
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/mandelbrot_fixed_checksum_unit.sv =====
// Top level of the fixed-point Mandelbrot escape-time checksum unit.
// Depends on mfc_pkg, mfc_ctrl, mfc_datapath (which holds mfc_div).
//
// Usage:
//   Drive width, height and iter_limit and raise start while busy is low;
//   the job item is taken at that clock edge and busy goes high.
//   Width and height saturate at MAX_DIM, the limit at MAX_ITER_LIMIT.
//   When the sweep is finished, done is high for exactly one cycle with the
//   checksum on its port; the receiver must take it then, it cannot stall.
//   busy drops the cycle after done, and the next job may start.
// Sequence after accept: an empty-grid check, the two grid-step divisions,
//   then the escape-time loop over all points, one point after another.
//   An empty grid (zero width or height) answers 0 without any division.
// Each escape-time iteration passes ST_MUL, through the three multipliers
// (two squares and the cross product), then ST_UPD, the magnitude compare
// and z update. The two grid steps come from a shared bit-serial divider.
// One job at a time; the next is taken only after done, once busy is low.
// Reset (arst_n low) returns the unit to idle at once;
// a job in flight is dropped without a result.
`default_nettype none

module mandelbrot_fixed_checksum_unit
	import mfc_pkg::*;
#(
	parameter int FRAC_BITS      = FRAC_BITS_DEF,
	parameter int MAX_DIM        = MAX_DIM_DEF,
	parameter int MAX_ITER_LIMIT = MAX_ITER_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [DIM_IN_W-1:0]  width,
	input  wire logic [DIM_IN_W-1:0]  height,
	input  wire logic [ITER_IN_W-1:0] iter_limit,
	output logic                      done,
	output logic      [SUM_W-1:0]     checksum
);

	mfc_cmd_t    cmd;
	mfc_status_t st;

	mfc_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.st    (st),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	mfc_datapath #(
		.FRAC_BITS     (FRAC_BITS),
		.MAX_DIM       (MAX_DIM),
		.MAX_ITER_LIMIT(MAX_ITER_LIMIT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.width     (width),
		.height    (height),
		.iter_limit(iter_limit),
		.cmd       (cmd),
		.st        (st),
		.checksum  (checksum)
	);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted job did not raise busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("unit did not return to idle after the result");

	a_done_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a job");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul, cmd.iterate, cmd.next_point, cmd.cap_im}))
		else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

// ===== dv/mandelbrot_fixed_checksum_unit_tb.sv =====
// Testbench for mandelbrot_fixed_checksum_unit: directed and random sweep jobs, each
// checksum compared against a fixed-point escape-time predictor in this file.
// Depends on mfc_pkg and the unit's RTL only.
`default_nettype none

module mandelbrot_fixed_checksum_unit_tb
	import mfc_pkg::*;
();

	localparam int FRAC     = FRAC_BITS_DEF;
	localparam int DIM_CAP  = MAX_DIM_DEF;
	localparam int ITER_CAP = MAX_ITER_DEF;
	localparam int DRAIN_CYCLES = 64;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [DIM_IN_W-1:0]  width = '0;
	logic [DIM_IN_W-1:0]  height = '0;
	logic [ITER_IN_W-1:0] iter_limit = '0;
	logic                 busy;
	logic                 done;
	logic [SUM_W-1:0]     checksum;

	logic [SUM_W-1:0] checksum_q[$];
	int jobs_sent = 0;
	int sums_checked = 0;
	int mismatches = 0;
	int max_points = 0;
	bit no_gaps = 1'b0;

	mandelbrot_fixed_checksum_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.width      (width),
		.height     (height),
		.iter_limit (iter_limit),
		.done       (done),
		.checksum   (checksum)
	);

	always #10 clk = ~clk;

	initial begin
		#2_000_000_000;
		$display("%0t sweep timed out with %0d checksums pending", $time, checksum_q.size());
		$display("[mandelbrot_fixed_checksum_unit] ERROR");
		$finish;
	end

	// Escape-time sweep over the saturated grid, summing counts mod 2^SUM_W.
	function automatic logic [SUM_W-1:0] sweep_checksum(input logic [DIM_IN_W-1:0] w_in,
			input logic [DIM_IN_W-1:0] h_in, input logic [ITER_IN_W-1:0] lim_in);
		longint one, four, re_min, im_min, step_re, step_im;
		longint cr, ci, zr, zi, rr, ii, nr;
		int cols, rows, lim, cnt;
		logic [SUM_W-1:0] total;
		one = longint'(1) << FRAC;
		four = longint'(4) << FRAC;
		re_min = -((5 * one) >>> 1);
		im_min = -one;
		cols = (int'(w_in) > DIM_CAP) ? DIM_CAP : int'(w_in);
		rows = (int'(h_in) > DIM_CAP) ? DIM_CAP : int'(h_in);
		lim = (int'(lim_in) > ITER_CAP) ? ITER_CAP : int'(lim_in);
		total = '0;
		if (cols != 0 && rows != 0) begin
			step_re = ((7 * one) >>> 1) / cols;
			step_im = (2 * one) / rows;
			for (int r = 0; r < rows; r++) begin
				ci = im_min + r * step_im;
				cr = re_min;
				for (int c = 0; c < cols; c++) begin
					zr = 0;
					zi = 0;
					cnt = 0;
					while (cnt < lim) begin
						rr = (zr * zr) >>> FRAC;
						ii = (zi * zi) >>> FRAC;
						if (rr + ii > four)
							break;
						nr = rr - ii + cr;
						// 2*zr*zi scaled down by FRAC is the product scaled by FRAC-1
						zi = ((zr * zi) >>> (FRAC - 1)) + ci;
						zr = nr;
						cnt++;
					end
					total = total + SUM_W'(cnt);
					cr += step_re;
				end
			end
		end
		return total;
	endfunction

	// Drive one job item, hold start until it is taken; start stays high on return.
	task automatic run_job(input int w, input int h, input int lim);
		int pts;
		while (!no_gaps && $urandom_range(99) < 17) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		width <= DIM_IN_W'(w);
		height <= DIM_IN_W'(h);
		iter_limit <= ITER_IN_W'(lim);
		do
			@(posedge clk);
		while (busy);
		checksum_q.push_back(sweep_checksum(DIM_IN_W'(w), DIM_IN_W'(h), ITER_IN_W'(lim)));
		jobs_sent++;
		pts = ((w > DIM_CAP) ? DIM_CAP : w) * ((h > DIM_CAP) ? DIM_CAP : h);
		if (pts > max_points)
			max_points = pts;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (checksum_q.size() == 0) begin
				$display("%0t unexpected checksum: expected none, actual %0d", $time, checksum);
				mismatches++;
			end else begin
				if (checksum !== checksum_q[0]) begin
					$display("%0t checksum mismatch: expected %0d, actual %0d",
						$time, checksum_q[0], checksum);
					mismatches++;
				end
				void'(checksum_q.pop_front());
				sums_checked++;
			end
		end
	end

	task automatic test_empty_grid();
		run_job(0, 5, 10);
		run_job(5, 0, 10);
		run_job(0, 0, 0);
		run_job(0, 2047, 1023);
	endtask

	task automatic test_zero_limit();
		run_job(4, 4, 0);
		run_job(1024, 1, 0);
	endtask

	task automatic test_saturation();
		run_job(2047, 1, 15);
		run_job(1024, 1, 15);
		run_job(1025, 3, 8);
		run_job(1, 2047, 1023);
		run_job(1, 1024, 50);
		run_job(1536, 1, 4);
	endtask

	task automatic test_iteration_limits();
		run_job(1, 1, 1);
		run_job(1, 1, 1023);
		// second row sits on the real axis, two of its three points stay bounded
		run_job(3, 2, 1023);
		run_job(2, 2, 512);
		run_job(7, 5, 1023);
		run_job(1024, 2, 30);
		run_job(16, 16, 100);
	endtask

	task automatic test_random_jobs(input int count);
		int roll;
		for (int n = 0; n < count; n++) begin
			// a stretch in the middle with the sender never pausing
			no_gaps = (n >= count / 3) && (n < count / 3 + 30);
			roll = $urandom_range(99);
			if (roll < 70)
				run_job($urandom_range(10), $urandom_range(10), $urandom_range(40));
			else if (roll < 85)
				run_job($urandom_range(4, 1), $urandom_range(4, 1), $urandom_range(1023));
			else if (roll < 93)
				run_job($urandom_range(2047), $urandom_range(2), $urandom_range(15));
			else
				run_job($urandom_range(2), $urandom_range(2047), $urandom_range(15));
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_grid();
		test_zero_limit();
		test_saturation();
		test_iteration_limits();
		test_random_jobs(80);
		start <= 1'b0;
		while (checksum_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d sweep jobs sent, %0d checksums checked, %0d mismatches",
			jobs_sent, sums_checked, mismatches);
		$display("covered empty grids, zero and full limits, saturated sizes, up to %0d points",
			max_points);
		if (mismatches == 0)
			$display("[mandelbrot_fixed_checksum_unit] OK");
		else
			$display("[mandelbrot_fixed_checksum_unit] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
src/mfc_pkg.sv
src/mfc_div.sv
src/mfc_datapath.sv
src/mfc_ctrl.sv
src/mandelbrot_fixed_checksum_unit.sv
dv/mandelbrot_fixed_checksum_unit_tb.sv
